// File: rtl/utd_pkg.sv
`timescale 1ns / 1ps

package utd_pkg;

  // One UTF-8 byte request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } byte_t;

  // One decoded code unit.
  typedef struct packed {
    logic [15:0] code_unit;
    logic [15:0] unit_count;
    logic        end_of_text;
    logic        truncated;
  } unit_t;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [1:0]  pending_bytes;
    logic [15:0] partial_value;
    logic [15:0] units_emitted;
  } dec_state_t;

endpackage

// File: rtl/utf8_to_ucs2_decoder_core.sv
`timescale 1ns / 1ps

// Channel  | Handshake                | Payload
// ---------+--------------------------+--------------------------------------
// byte     | byte_valid / byte_ready  | byte_data: in_byte, last_byte
// unit     | unit_valid / unit_ready  | unit_data: code_unit, unit_count,
//          |                          |   end_of_text, truncated
//
// One byte is accepted per cycle while byte_ready is high; a unit is offered once the
// byte completing it has passed the input register and then one decode step into
// the result register. The decode step is a single mask, shift and saturating add.
// Reset (rst, synchronous) empties both registers and clears the decoder state.
// A stalled unit holds the input register; the byte side stalls only when
// both registers are full and the unit is not taken.
module utf8_to_ucs2_decoder_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  utd_pkg::byte_t   byte_data,
  output logic             unit_valid,
  input  logic             unit_ready,
  output utd_pkg::unit_t   unit_data
);
  import utd_pkg::*;

  logic       req_valid;
  byte_t      req;
  dec_state_t dec_state;
  dec_state_t upd_state;
  logic       emit;
  unit_t      unit;
  logic       advance;

  // The held byte moves on when the result register is free or being drained.
  assign advance    = req_valid && (!unit_valid || unit_ready);
  assign byte_ready = !req_valid || advance;

  utd_step u_step (
    .cur_state (dec_state),
    .req       (req),
    .upd_state (upd_state),
    .emit      (emit),
    .unit      (unit)
  );

  // Control and decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid  <= 1'b0;
      unit_valid <= 1'b0;
      dec_state  <= '0;
    end else begin
      if (byte_ready) begin
        req_valid <= byte_valid;
      end
      if (advance) begin
        dec_state  <= upd_state;
        unit_valid <= emit;
      end else if (unit_ready) begin
        unit_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      req <= byte_data;
    end
    if (advance && emit) begin
      unit_data <= unit;
    end
  end

endmodule

// File: rtl/utd_step.sv
`timescale 1ns / 1ps

// Decodes one byte against the current state: next state and at most one unit.
module utd_step (
  input  utd_pkg::dec_state_t cur_state,
  input  utd_pkg::byte_t      req,
  output utd_pkg::dec_state_t upd_state,
  output logic                emit,
  output utd_pkg::unit_t      unit
);
  import utd_pkg::*;

  localparam logic [7:0]  AsciiMax    = 8'h7F;
  localparam logic [7:0]  TwoByteMax  = 8'hDF;
  localparam logic [7:0]  Lead2Mask   = 8'h1F;
  localparam logic [7:0]  Lead3Mask   = 8'h0F;
  localparam logic [7:0]  ContMask    = 8'h3F;
  localparam logic [15:0] CountMax    = 16'hFFFF;

  logic [7:0]  b;
  logic [5:0]  cont_bits;
  logic [15:0] cont_shifted;
  logic [15:0] merged;
  logic [1:0]  pend_dec;
  logic        trunc;
  logic [15:0] unit_value;
  logic [15:0] count_next;
  dec_state_t  seq_state;

  assign b         = req.in_byte;
  assign cont_bits = 6'(b & ContMask);
  assign pend_dec  = cur_state.pending_bytes - 2'd1;

  // Continuation bits land 6 bits higher for each byte still to come.
  always_comb begin
    case (pend_dec)
      2'd0:    cont_shifted = {10'd0, cont_bits};
      2'd1:    cont_shifted = {4'd0, cont_bits, 6'd0};
      2'd2:    cont_shifted = {cont_bits[3:0], 12'd0};
      default: cont_shifted = 16'd0;
    endcase
  end

  assign merged = cur_state.partial_value | cont_shifted;

  // Sequence tracking and the choice of whether a unit comes out.
  always_comb begin
    seq_state  = cur_state;
    emit       = 1'b0;
    trunc      = 1'b0;
    unit_value = 16'd0;
    if (cur_state.pending_bytes == 2'd0) begin
      if (b <= AsciiMax) begin
        emit       = 1'b1;
        unit_value = {8'd0, b};
      end else begin
        if (b <= TwoByteMax) begin
          seq_state.partial_value = {5'd0, 5'(b & Lead2Mask), 6'd0};
          seq_state.pending_bytes = 2'd1;
        end else begin
          seq_state.partial_value = {4'(b & Lead3Mask), 12'd0};
          seq_state.pending_bytes = 2'd2;
        end
        if (req.last_byte) begin
          emit       = 1'b1;
          trunc      = 1'b1;
          unit_value = seq_state.partial_value;
        end
      end
    end else begin
      seq_state.partial_value = merged;
      seq_state.pending_bytes = pend_dec;
      if (pend_dec == 2'd0) begin
        emit                    = 1'b1;
        unit_value              = merged;
        seq_state.partial_value = 16'd0;
      end else if (req.last_byte) begin
        emit       = 1'b1;
        trunc      = 1'b1;
        unit_value = merged;
      end
    end
  end

  // Saturating unit count.
  assign count_next = (cur_state.units_emitted != CountMax) ?
                      cur_state.units_emitted + 16'd1 : CountMax;

  // The final byte of a text clears all state.
  always_comb begin
    upd_state = seq_state;
    if (emit) begin
      upd_state.units_emitted = count_next;
    end
    if (req.last_byte) begin
      upd_state = '0;
    end
  end

  assign unit.code_unit   = unit_value;
  assign unit.unit_count  = count_next;
  assign unit.end_of_text = req.last_byte;
  assign unit.truncated   = trunc;

endmodule

// File: rtl/utd_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the decoded unit stream.
module utd_checker (
  input logic           clk,
  input logic           rst,
  input logic           unit_valid,
  input logic           unit_ready,
  input utd_pkg::unit_t unit_data
);
  import utd_pkg::*;

  // A stalled unit stays offered and unchanged.
  a_unit_hold: assert property (@(posedge clk) disable iff (rst)
    unit_valid && !unit_ready |=> unit_valid && $stable(unit_data))
    else $error("unit request dropped or changed while stalled");

  // Every unit counts itself, so the count is never zero.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    unit_valid |-> unit_data.unit_count != 16'd0)
    else $error("unit count is zero on a valid unit");

  // A truncated unit is always the end of its text.
  a_trunc_end: assert property (@(posedge clk) disable iff (rst)
    unit_valid && unit_data.truncated |-> unit_data.end_of_text)
    else $error("truncated unit without end of text");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !unit_valid)
    else $error("unit valid right after reset");

endmodule

bind utf8_to_ucs2_decoder_core utd_checker u_utd_checker (
  .clk        (clk),
  .rst        (rst),
  .unit_valid (unit_valid),
  .unit_ready (unit_ready),
  .unit_data  (unit_data)
);
